>>> src/assert_macros.svh
// Assertion helpers for the statistics block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("check failed");
`define CHK_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("check failed");
`endif

>>> src/rss_pkg.sv
`default_nettype none
package rss_pkg;
    localparam int COUNT_LOG2_DEF = 20;
    localparam int SAMPLE_BITS_DEF = 20;
    localparam int FRACTION_BITS_DEF = 4;
    localparam int IN_W = 20;
    localparam int CNT_W = 21;
    localparam int SUM_W = 40;
    localparam int SQ_W = 60;
    localparam int SD_W = 19;
    localparam int DIV_W = 64;

    typedef enum logic [2:0] {
        BK_IDLE, BK_DIV_SUM, BK_DIV_SQ, BK_MSQ, BK_SQRT, BK_OUT
    } bk_state_t;

    typedef struct packed {
        logic signed [IN_W-1:0] min_v;
        logic signed [IN_W-1:0] max_v;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0] sumsq;
        logic [CNT_W-1:0] cnt;
        logic dropped;
    } set_stats_t;
endpackage
`default_nettype wire

>>> src/rss_front.sv
`default_nettype none
module rss_front #(
    parameter int COUNT_LOG2 = rss_pkg::COUNT_LOG2_DEF,
    parameter int SAMPLE_BITS = rss_pkg::SAMPLE_BITS_DEF
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire logic [rss_pkg::IN_W-1:0] s_sample,
    input wire logic s_last,
    output logic q_valid,
    input wire logic q_ready,
    output rss_pkg::set_stats_t q_data
);
    localparam int CW = COUNT_LOG2 + 1;
    localparam logic [CW-1:0] LIMIT = CW'(1) << COUNT_LOG2;
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] min_reg, min_next, max_reg, max_next;
    logic signed [rss_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [rss_pkg::SQ_W-1:0] sq_reg, sq_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic drop_reg, drop_next;
    logic pend_reg, pend_next;
    logic signed [SAMPLE_BITS-1:0] s;
    logic [SAMPLE_BITS-1:0] mag;
    logic take;

    assign s = s_sample[SAMPLE_BITS-1:0];
    assign mag = s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : SAMPLE_BITS'(s);
    assign s_ready = !pend_reg;
    assign take = s_valid && s_ready;
    assign q_valid = pend_reg;
    assign q_data.min_v = rss_pkg::IN_W'(min_reg);
    assign q_data.max_v = rss_pkg::IN_W'(max_reg);
    assign q_data.sum = sum_reg;
    assign q_data.sumsq = sq_reg;
    assign q_data.cnt = rss_pkg::CNT_W'(cnt_reg);
    assign q_data.dropped = drop_reg;

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        sum_next = sum_reg;
        sq_next = sq_reg;
        cnt_next = cnt_reg;
        drop_next = drop_reg;
        pend_next = pend_reg;
        if (pend_reg && q_ready) begin
            pend_next = 1'b0;
            min_next = SMAX;
            max_next = SMIN;
            sum_next = '0;
            sq_next = '0;
            cnt_next = '0;
            drop_next = 1'b0;
        end else if (take) begin
            if (cnt_reg < LIMIT) begin
                if (s < min_reg) min_next = s;
                if (s > max_reg) max_next = s;
                sum_next = sum_reg + rss_pkg::SUM_W'(s);
                sq_next = sq_reg + rss_pkg::SQ_W'({{SAMPLE_BITS{1'b0}}, mag} * mag);
                cnt_next = cnt_reg + CW'(1);
            end else begin
                drop_next = 1'b1;
            end
            pend_next = s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            min_reg <= SMAX;
            max_reg <= SMIN;
            sum_reg <= '0;
            sq_reg <= '0;
            cnt_reg <= '0;
            drop_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            min_reg <= min_next;
            max_reg <= max_next;
            sum_reg <= sum_next;
            sq_reg <= sq_next;
            cnt_reg <= cnt_next;
            drop_reg <= drop_next;
        end
    end
endmodule
`default_nettype wire

>>> src/rss_back.sv
`default_nettype none
module rss_back (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic q_valid,
    output logic q_ready,
    input wire rss_pkg::set_stats_t q_data,
    output logic m_valid,
    input wire logic m_ready,
    output logic [rss_pkg::IN_W-1:0] m_min_value,
    output logic [rss_pkg::IN_W-1:0] m_max_value,
    output logic [rss_pkg::IN_W-1:0] m_mean_value,
    output logic [rss_pkg::SD_W-1:0] m_std_dev,
    output logic [rss_pkg::CNT_W-1:0] m_sample_count,
    output logic m_overflow
);
    localparam int W = rss_pkg::DIV_W;
    localparam logic [W-1:0] SDMAX = W'(524287);
    rss_pkg::bk_state_t st_reg, st_next;
    rss_pkg::set_stats_t d_reg, d_next;
    logic [W-1:0] rem_reg, rem_next, quo_reg, quo_next;
    logic [6:0] it_reg, it_next;
    logic neg_reg, neg_next;
    logic [rss_pkg::IN_W-1:0] mean_reg, mean_next;
    logic [W-1:0] avg_reg, avg_next;
    logic [W-1:0] bit_reg, bit_next;
    logic [rss_pkg::SD_W-1:0] sd_reg, sd_next;
    logic ov_reg, ov_next;
    logic [W:0] trial;
    logic [W-1:0] divisor, sqt;
    logic [rss_pkg::IN_W-1:0] mmag;

    assign divisor = W'(d_reg.cnt);
    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, divisor};
    assign sqt = quo_reg + bit_reg;
    assign mmag = mean_reg[rss_pkg::IN_W-1] ? -mean_reg : mean_reg;
    assign q_ready = (st_reg == rss_pkg::BK_IDLE);
    assign m_min_value = d_reg.min_v;
    assign m_max_value = d_reg.max_v;
    assign m_mean_value = mean_reg;
    assign m_std_dev = sd_reg;
    assign m_sample_count = d_reg.cnt;
    assign m_overflow = ov_reg;

    always_comb begin
        st_next = st_reg;
        d_next = d_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        it_next = it_reg;
        neg_next = neg_reg;
        mean_next = mean_reg;
        avg_next = avg_reg;
        bit_next = bit_reg;
        sd_next = sd_reg;
        ov_next = ov_reg;
        m_valid = 1'b0;
        unique case (st_reg)
            rss_pkg::BK_IDLE: begin
                if (q_valid) begin
                    d_next = q_data;
                    ov_next = q_data.dropped;
                    st_next = rss_pkg::BK_DIV_SUM;
                    rem_next = '0;
                    neg_next = q_data.sum[rss_pkg::SUM_W-1];
                    quo_next = W'(q_data.sum[rss_pkg::SUM_W-1] ? -q_data.sum : q_data.sum);
                    it_next = 7'(W);
                end
            end
            rss_pkg::BK_DIV_SUM, rss_pkg::BK_DIV_SQ: begin
                if (!trial[W]) begin
                    rem_next = trial[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                it_next = it_reg - 7'(1);
                if (it_reg == 7'(1)) begin
                    rem_next = '0;
                    it_next = 7'(W);
                    if (st_reg == rss_pkg::BK_DIV_SUM) begin
                        mean_next = neg_reg ? -quo_next[rss_pkg::IN_W-1:0]
                                            : quo_next[rss_pkg::IN_W-1:0];
                        quo_next = W'(d_reg.sumsq);
                        st_next = rss_pkg::BK_DIV_SQ;
                    end else begin
                        avg_next = quo_next;
                        st_next = rss_pkg::BK_MSQ;
                    end
                end
            end
            rss_pkg::BK_MSQ: begin
                if (avg_reg > W'(mmag * mmag)) rem_next = avg_reg - W'(mmag * mmag);
                else rem_next = '0;
                quo_next = '0;
                bit_next = W'(1) << 62;
                st_next = rss_pkg::BK_SQRT;
            end
            rss_pkg::BK_SQRT: begin
                if (bit_reg == '0) begin
                    sd_next = (quo_reg > SDMAX) ? rss_pkg::SD_W'(SDMAX)
                                                : quo_reg[rss_pkg::SD_W-1:0];
                    st_next = rss_pkg::BK_OUT;
                end else begin
                    if (rem_reg >= sqt) begin
                        rem_next = rem_reg - sqt;
                        quo_next = (quo_reg >> 1) + bit_reg;
                    end else begin
                        quo_next = quo_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            rss_pkg::BK_OUT: begin
                m_valid = 1'b1;
                if (m_ready) st_next = rss_pkg::BK_IDLE;
            end
            default: st_next = rss_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= rss_pkg::BK_IDLE;
        end else begin
            st_reg <= st_next;
        end
        d_reg <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        it_reg <= it_next;
        neg_reg <= neg_next;
        mean_reg <= mean_next;
        avg_reg <= avg_next;
        bit_reg <= bit_next;
        sd_reg <= sd_next;
        ov_reg <= ov_next;
    end
endmodule
`default_nettype wire

>>> src/running_sample_statistics.sv
`default_nettype none
// Streaming min/max/mean/standard deviation. Samples are taken one per cycle;
// the sample marked last closes the set. The front accumulator then holds
// the set's totals until the back unit, once idle, takes them. The back unit
// runs two restoring divides (sum and sum of squares by the count), forms the
// variance and takes its bit-pair square root before m_valid rises. While a
// closed set waits for the back unit, new samples are held off.
`include "assert_macros.svh"
module running_sample_statistics #(
    parameter int COUNT_LOG2 = rss_pkg::COUNT_LOG2_DEF,
    parameter int SAMPLE_BITS = rss_pkg::SAMPLE_BITS_DEF
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire logic [rss_pkg::IN_W-1:0] s_sample,
    input wire logic s_last,
    output logic m_valid,
    input wire logic m_ready,
    output logic [rss_pkg::IN_W-1:0] m_min_value,
    output logic [rss_pkg::IN_W-1:0] m_max_value,
    output logic [rss_pkg::IN_W-1:0] m_mean_value,
    output logic [rss_pkg::SD_W-1:0] m_std_dev,
    output logic [rss_pkg::CNT_W-1:0] m_sample_count,
    output logic m_overflow
);
    logic q_valid, q_ready;
    rss_pkg::set_stats_t q_data;

    rss_front #(.COUNT_LOG2(COUNT_LOG2), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_sample, .s_last,
        .q_valid, .q_ready, .q_data
    );

    rss_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_min_value, .m_max_value, .m_mean_value,
        .m_std_dev, .m_sample_count, .m_overflow
    );

    `CHK_NEXT(a_hold_after_last, aclk, aresetn, s_valid && s_ready && s_last, !s_ready)
    `CHK_IMPL(a_count_nonzero, aclk, aresetn, m_valid, m_sample_count != '0)
    `CHK_IMPL(a_minmax_order, aclk, aresetn, m_valid,
        $signed(m_min_value) <= $signed(m_max_value))
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    localparam int LIMIT_LOG2 = rss_pkg::COUNT_LOG2_DEF;
    localparam int TOTAL_ITEMS = 900;

    typedef struct {
        logic [rss_pkg::IN_W-1:0] min_v;
        logic [rss_pkg::IN_W-1:0] max_v;
        logic [rss_pkg::IN_W-1:0] mean_v;
        logic [rss_pkg::SD_W-1:0] sd;
        logic [rss_pkg::CNT_W-1:0] cnt;
        logic ovf;
    } set_result_t;

    class stats_scoreboard;
        longint smin, smax, ssum, scnt;
        longint unsigned ssq;
        bit sdrop;
        set_result_t pending[$];
        int errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            smin = 524287;
            smax = -524288;
            ssum = 0;
            ssq = 0;
            scnt = 0;
            sdrop = 0;
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void note_sample(logic [rss_pkg::IN_W-1:0] smp, logic lst);
            longint s, mean, mm;
            longint unsigned avg, var_v, sd;
            set_result_t res;
            s = longint'($signed(smp));
            if (scnt < (64'd1 << LIMIT_LOG2)) begin
                if (s < smin) smin = s;
                if (s > smax) smax = s;
                ssum += s;
                ssq += longint'(s * s);
                scnt++;
            end else begin
                sdrop = 1;
            end
            if (!lst) return;
            mean = ssum / scnt;
            mm = mean < 0 ? -mean : mean;
            avg = ssq / longint'(scnt);
            var_v = (avg > mm * mm) ? avg - mm * mm : 0;
            sd = int_root(var_v);
            if (sd > 524287) sd = 524287;
            res.min_v = smin[rss_pkg::IN_W-1:0];
            res.max_v = smax[rss_pkg::IN_W-1:0];
            res.mean_v = mean[rss_pkg::IN_W-1:0];
            res.sd = sd[rss_pkg::SD_W-1:0];
            res.cnt = scnt[rss_pkg::CNT_W-1:0];
            res.ovf = sdrop;
            pending.insert(pending.size(), res);
            clear();
        endfunction

        function void check_result(set_result_t got);
            set_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, min %h", $time, got.min_v);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.min_v !== e.min_v) begin
                $display("%0t: min exp %h act %h", $time, e.min_v, got.min_v);
                errors++;
            end
            if (got.max_v !== e.max_v) begin
                $display("%0t: max exp %h act %h", $time, e.max_v, got.max_v);
                errors++;
            end
            if (got.mean_v !== e.mean_v) begin
                $display("%0t: mean exp %h act %h", $time, e.mean_v, got.mean_v);
                errors++;
            end
            if (got.sd !== e.sd) begin
                $display("%0t: std exp %h act %h", $time, e.sd, got.sd);
                errors++;
            end
            if (got.cnt !== e.cnt) begin
                $display("%0t: count exp %h act %h", $time, e.cnt, got.cnt);
                errors++;
            end
            if (got.ovf !== e.ovf) begin
                $display("%0t: overflow exp %h act %h", $time, e.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [rss_pkg::IN_W-1:0] s_sample = '0;
    logic s_last = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [rss_pkg::IN_W-1:0] m_min_value, m_max_value, m_mean_value;
    logic [rss_pkg::SD_W-1:0] m_std_dev;
    logic [rss_pkg::CNT_W-1:0] m_sample_count;
    logic m_overflow;

    stats_scoreboard sb = new();
    int sent = 0;
    bit quiet = 0;
    bit hold_sink = 0;

    running_sample_statistics dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    always @(posedge aclk) begin
        set_result_t r;
        if (aresetn && s_valid && s_ready) sb.note_sample(s_sample, s_last);
        if (aresetn && m_valid && m_ready) begin
            r.min_v = m_min_value;
            r.max_v = m_max_value;
            r.mean_v = m_mean_value;
            r.sd = m_std_dev;
            r.cnt = m_sample_count;
            r.ovf = m_overflow;
            sb.check_result(r);
        end
    end

    task automatic send_sample(logic [rss_pkg::IN_W-1:0] smp, logic lst);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid <= 1;
        s_sample <= smp;
        s_last <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    function automatic logic [rss_pkg::IN_W-1:0] rand_sample();
        unique case ($urandom_range(0, 4))
            0: return 20'h7FFFF;
            1: return 20'h80000;
            2: return rss_pkg::IN_W'($urandom_range(0, 40)) - rss_pkg::IN_W'(20);
            default: return rss_pkg::IN_W'($urandom);
        endcase
    endfunction

    // receiver side: random stalls, one long hold
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                hold_sink = 0;
                m_ready <= 0;
                repeat (400) @(negedge aclk);
                m_ready <= 1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
                m_ready <= 1;
            end else begin
                m_ready <= 1;
            end
        end
    end

    initial begin
        int n, i;
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        send_sample(20'h7FFFF, 1);
        send_sample(20'h80000, 1);
        send_sample(20'h80000, 0);
        send_sample(20'h80000, 1);
        send_sample(20'h7FFFF, 0);
        send_sample(20'h7FFFF, 1);
        send_sample(20'h7FFFF, 0);
        send_sample(20'h80000, 1);
        send_sample(20'h00000, 1);
        send_sample(20'hFFFFF, 0);
        send_sample(20'h00000, 1);
        send_sample(20'h00003, 0);
        send_sample(20'h00000, 0);
        send_sample(20'h00000, 1);
        send_sample(20'hAAAAA, 0);
        send_sample(20'h55555, 1);
        hold_sink = 1;
        for (i = 0; i < 6; i++) send_sample(rand_sample(), 1);
        while (sent < TOTAL_ITEMS) begin
            if (sent > TOTAL_ITEMS - 150) quiet = 1;
            n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 20);
            for (i = 0; i < n; i++) send_sample(rand_sample(), i == n - 1);
        end
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0) $display("running_sample_statistics verification clean");
        else $display("running_sample_statistics verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("running_sample_statistics verification failed");
        $finish;
    end
endmodule
